@@ hdl/bse_pkg.sv @@
// Package with the shared types and constants of the bounded stack engine.
`default_nettype none
package bse_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W = 32;
    localparam int POS_W = 7;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CHANGE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BADPOS    = 2'd3
    } status_t;

    typedef struct packed {
        op_t                       opcode;
        logic signed [DATA_W-1:0]  data_in;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  data_out;
        logic [COUNT_W-1:0]        count;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } state_t;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic load_rsp;
    } ctrl_cmd_t;

    typedef struct packed {
        logic rsp_busy;
    } ctrl_sts_t;

endpackage
`default_nettype wire

@@ hdl/bse_ctrl.sv @@
// Controller state machine that sequences one word through the stack datapath.
`default_nettype none
module bse_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire bse_pkg::ctrl_sts_t sts,
    output bse_pkg::ctrl_cmd_t      cmd
);
    import bse_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        req_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!sts.rsp_busy)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/bse_datapath.sv @@
// Stack datapath: entry memory, fill count, request and result registers.
`default_nettype none
module bse_datapath #(
    parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bse_pkg::req_t      req,
    input  wire bse_pkg::ctrl_cmd_t cmd,
    output bse_pkg::ctrl_sts_t      sts,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output bse_pkg::rsp_t           rsp
);
    import bse_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [DATA_W-1:0]  mem_reg [DEPTH];
    logic [DATA_W-1:0]  rd_data_reg;
    req_t               req_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    status_t            status_reg;
    status_t            status_next;
    logic [DATA_W-1:0]  value_reg;
    logic [DATA_W-1:0]  value_next;
    logic               use_rd_reg;
    logic               use_rd_next;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               full;
    logic               empty;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   chg_diff;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [CNT_W+COUNT_W-1:0] cnt_wide;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_ext  = CMP_W'(cnt_reg);
    assign pos_ext  = CMP_W'(req_reg.position);
    assign chg_diff = cnt_ext - pos_ext;
    assign cnt_wide = {{COUNT_W{1'b0}}, cnt_reg};

    always_comb
    begin
        cnt_next    = cnt_reg;
        status_next = ST_OK;
        value_next  = '0;
        use_rd_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = cnt_reg[AW-1:0];
        rd_en       = 1'b0;
        rd_addr     = cnt_m1[AW-1:0];
        case (req_reg.opcode)
            OP_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_en      = cmd.exec;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    value_next = req_reg.data_in;
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    rd_en       = cmd.exec;
                    use_rd_next = 1'b1;
                    cnt_next    = cnt_m1;
                end
            end
            OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    rd_en       = cmd.exec;
                    use_rd_next = 1'b1;
                end
            end
            default:
            begin
                if ((pos_ext == '0) || (pos_ext > cnt_ext))
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    wr_en      = cmd.exec;
                    wr_addr    = chg_diff[AW-1:0];
                    value_next = req_reg.data_in;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= req_reg.data_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            use_rd_reg <= use_rd_next;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.status   <= status_reg;
            rsp_reg.data_out <= use_rd_reg ? rd_data_reg : value_reg;
            rsp_reg.count    <= cnt_wide[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                cnt_reg <= cnt_next;
            end
            if (cmd.load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.rsp_busy = rsp_valid_reg && !rsp_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

endmodule
`default_nettype wire

@@ hdl/bounded_stack_engine.sv @@
// Top level of the bounded stack engine: controller plus datapath.
// The engine holds up to DEPTH signed 32-bit entries in a single-port memory with a registered
// read and answers every request word with one result word carrying status, data and the count
// held afterward. A request is registered on acceptance, executed against the memory and fill
// count in the next cycle, and its result is loaded into the output register from the
// response state, which waits only while an earlier result is still held and not taken.
// The next request is accepted in the cycle after the result register is loaded, whether or
// not that result has been taken. Entries come up undefined; only entries written by a push
// are ever read. The count is reported modulo 128.
`default_nettype none
module bounded_stack_engine #(
    parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire bse_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output bse_pkg::rsp_t      rsp
);
    import bse_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    bse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bse_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

@@ hdl/bse_checker.sv @@
// Port-level assertion checker for the bounded stack engine and its bind.
`default_nettype none
module bse_checker #(
    parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire bse_pkg::rsp_t rsp
);
    import bse_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);
    localparam logic SMALL = (DEPTH < 128);

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("Result word dropped or changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Second request word accepted while one is in progress.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.data_out == '0))
        else $error("Failed operation returned nonzero data.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_OVERFLOW) |-> (rsp.count == FULL_COUNT))
        else $error("Overflow reported while the stack is not full.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SMALL |-> (rsp.count <= FULL_COUNT) &&
        ((rsp.status != ST_UNDERFLOW) || (rsp.count == '0)))
        else $error("Reported count out of range or underflow on a nonempty stack.");

endmodule

bind bounded_stack_engine bse_checker #(.DEPTH(DEPTH)) u_bse_checker (.*);
`default_nettype wire
